>>> hw/rtl/etfp_pkg.sv
`default_nettype none
package etfp_pkg;

  localparam int XW    = 9;
  localparam int FRACW = 28;
  localparam int ZW    = 35;
  localparam int PRW   = 41;
  localparam int LIMW  = 16;
  localparam int IDXW  = 10;
  localparam int CHW   = 8;
  localparam int INW   = 24;
  localparam int OUTW  = 72;
  localparam int AW    = 5;

  localparam logic signed [ZW-1:0] Z_MAX = 35'sd17179869183;
  // 400 in Q.28
  localparam logic signed [PRW:0] ESC_SQ = 42'sd107374182400;

  localparam logic [2:0] REG_X_MIN      = 3'd0;
  localparam logic [2:0] REG_Y_MAX      = 3'd1;
  localparam logic [2:0] REG_RE_STEP    = 3'd2;
  localparam logic [2:0] REG_IM_STEP    = 3'd3;
  localparam logic [2:0] REG_JULIA_C_RE = 3'd4;
  localparam logic [2:0] REG_JULIA_C_IM = 3'd5;
  localparam logic [2:0] REG_ITER_LIMIT = 3'd6;
  localparam logic [2:0] REG_JULIA_MODE = 3'd7;

  localparam logic [1:0] SEG_RED_YEL  = 2'd0;
  localparam logic [1:0] SEG_YEL_GRN  = 2'd1;
  localparam logic [1:0] SEG_GRN_CYN  = 2'd2;
  localparam logic [1:0] SEG_CYN_BLU  = 2'd3;

  typedef struct packed {
    logic signed [31:0] x_min;
    logic signed [31:0] y_max;
    logic signed [31:0] re_step;
    logic signed [31:0] im_step;
    logic signed [31:0] julia_c_re;
    logic signed [31:0] julia_c_im;
    logic [LIMW-1:0]    iteration_limit;
    logic               julia_mode;
  } cfg_t;

  typedef struct packed {
    logic [XW-1:0]      px;
    logic [XW-1:0]      py;
    logic signed [31:0] pre;
    logic signed [31:0] pim;
  } point_t;

  typedef struct packed {
    logic [CHW-1:0] red;
    logic [CHW-1:0] green;
    logic [CHW-1:0] blue;
  } rgb_t;

  function automatic rgb_t ramp_color(input logic [IDXW-1:0] idx);
    rgb_t c;
    logic [CHW-1:0] i;
    i = idx[CHW-1:0];
    case (idx[IDXW-1:CHW])
      SEG_RED_YEL: c = '{8'hFF, i, 8'h00};
      SEG_YEL_GRN: c = '{8'hFF - i, 8'hFF, 8'h00};
      SEG_GRN_CYN: c = '{8'h00, 8'hFF, i};
      SEG_CYN_BLU: c = '{8'h00, 8'hFF - i, 8'hFF};
      default:     c = '{8'h00, 8'h00, 8'h00};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/etfp_front.sv
`default_nettype none
module etfp_front (
  input  wire                          clk,
  input  wire                          rst,
  input  etfp_pkg::cfg_t               cfg,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [etfp_pkg::INW-1:0]      s_tdata,
  output logic                         push,
  output etfp_pkg::point_t             push_data,
  input  wire                          q_ready
);

  logic                 v1;
  logic [8:0]           px, py;
  logic signed [41:0]   prx, pry;
  logic signed [42:0]   sumx, sumy;

  function automatic logic signed [31:0] clamp32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -43'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  assign s_tready = !v1;
  assign push     = v1;

  always_comb begin
    sumx = {{11{cfg.x_min[31]}}, cfg.x_min} + {prx[41], prx};
    sumy = {{11{cfg.y_max[31]}}, cfg.y_max} - {pry[41], pry};
    push_data.px  = px;
    push_data.py  = py;
    push_data.pre = clamp32(sumx);
    push_data.pim = clamp32(sumy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tvalid && !v1) begin
      v1 <= 1'b1;
    end else if (v1 && q_ready) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && !v1) begin
      px  <= s_tdata[8:0];
      py  <= s_tdata[17:9];
      prx <= 42'($signed({1'b0, s_tdata[8:0]}) * cfg.re_step);
      pry <= 42'($signed({1'b0, s_tdata[17:9]}) * cfg.im_step);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/etfp_queue.sv
`default_nettype none
module etfp_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  etfp_pkg::point_t  push_data,
  output logic              ready,
  input  wire               pop,
  output logic              valid,
  output etfp_pkg::point_t  data
);

  etfp_pkg::point_t mem [2];
  logic       wptr, rptr;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  assign ready   = (cnt != 2'd2);
  assign valid   = (cnt != 2'd0);
  assign data    = mem[rptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop) rptr <= !rptr;
      if (do_push && !do_pop) cnt <= cnt + 2'd1;
      else if (do_pop && !do_push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_data;
  end

endmodule
`default_nettype wire

>>> hw/rtl/etfp_mul.sv
`default_nettype none
module etfp_mul (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire signed [etfp_pkg::ZW-1:0]    a,
  input  wire signed [etfp_pkg::ZW-1:0]    b,
  output logic                             done,
  output logic signed [etfp_pkg::PRW-1:0]  res
);

  logic [33:0] ua, ub;
  logic        neg;
  logic [1:0]  step;
  logic        busy;
  logic [67:0] acc;
  logic [16:0] opa, opb;
  logic [33:0] pp;
  logic [67:0] pp_sh;
  logic [34:0] abs_a, abs_b;
  logic [39:0] mag;

  assign abs_a = a[34] ? 35'(-a) : a;
  assign abs_b = b[34] ? 35'(-b) : b;

  // partial products: low*low, low*high, high*low, high*high
  always_comb begin
    case (step)
      2'd0: begin opa = ua[16:0];  opb = ub[16:0]; end
      2'd1: begin opa = ua[16:0];  opb = ub[33:17]; end
      2'd2: begin opa = ua[33:17]; opb = ub[16:0]; end
      default: begin opa = ua[33:17]; opb = ub[33:17]; end
    endcase
    pp = opa * opb;
    case (step)
      2'd0:    pp_sh = {34'd0, pp};
      2'd1,
      2'd2:    pp_sh = {17'd0, pp, 17'd0};
      default: pp_sh = {pp, 34'd0};
    endcase
  end

  assign mag = acc[67:28];
  assign res = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= abs_a[33:0];
      ub  <= abs_b[33:0];
      neg <= a[34] ^ b[34];
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_sh;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/etfp_back.sv
`default_nettype none
module etfp_back (
  input  wire                          clk,
  input  wire                          rst,
  input  etfp_pkg::cfg_t               cfg,
  input  wire                          q_valid,
  input  etfp_pkg::point_t             q_data,
  output logic                         q_pop,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [etfp_pkg::OUTW-1:0]    m_tdata,
  output logic                         m_tuser
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_WAIT  = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  logic signed [34:0] zr, zi;
  logic signed [31:0] cr, ci;
  logic [15:0] count;
  logic        first;
  logic        in_set;
  logic [15:0] rem;
  logic [9:0]  numlo;
  logic [9:0]  q;
  logic [3:0]  dcnt;
  logic [8:0]  px, py;

  logic signed [40:0] sq_r, sq_i, pr;
  logic               done0, done1, done2;
  logic               mul_done;
  logic               mstart;
  logic signed [41:0] mag_sq;
  logic               run;
  logic signed [43:0] t_i, t_r;
  logic [25:0]        num;
  logic [16:0]        remsh;
  logic               ge;
  logic [9:0]         idx;
  etfp_pkg::rgb_t     rgb;
  logic               out_load;

  function automatic logic signed [34:0] sat_z(input logic signed [43:0] v);
    if (v > $signed({9'd0, etfp_pkg::Z_MAX})) return etfp_pkg::Z_MAX;
    else if (v < -$signed({9'd0, etfp_pkg::Z_MAX})) return -etfp_pkg::Z_MAX;
    else return v[34:0];
  endfunction

  assign mstart   = (state == S_START);
  assign mul_done = done0 && done1 && done2;

  etfp_mul u_mul_rr (.clk, .rst, .start(mstart), .a(zr), .b(zr), .done(done0), .res(sq_r));
  etfp_mul u_mul_ii (.clk, .rst, .start(mstart), .a(zi), .b(zi), .done(done1), .res(sq_i));
  etfp_mul u_mul_ri (.clk, .rst, .start(mstart), .a(zr), .b(zi), .done(done2), .res(pr));

  always_comb begin
    mag_sq = {sq_r[40], sq_r} + {sq_i[40], sq_i};
    run    = first || ((mag_sq <= etfp_pkg::ESC_SQ) && (count < cfg.iteration_limit));
    t_i    = {{2{pr[40]}}, pr, 1'b0} + {{12{ci[31]}}, ci};
    t_r    = {{3{sq_r[40]}}, sq_r} - {{3{sq_i[40]}}, sq_i} + {{12{cr[31]}}, cr};
    num    = {count, 10'd0} - {10'd0, count};
    remsh  = {rem, numlo[9]};
    ge     = (remsh >= {1'b0, cfg.iteration_limit});
    if (in_set) idx = '0;
    else if (q == '0) idx = 10'd1023;
    else idx = 10'(-q);
    rgb = in_set ? '{8'h00, 8'h00, 8'h00} : etfp_pkg::ramp_color(idx);
  end

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE:  if (q_valid) state <= S_START;
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            if (run) state <= S_START;
            else if (count >= cfg.iteration_limit) state <= S_OUT;
            else state <= S_DIV;
          end
        end
        S_DIV:   if (dcnt == 4'(etfp_pkg::IDXW - 1)) state <= S_OUT;
        S_OUT:   if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        px    <= q_data.px;
        py    <= q_data.py;
        zr    <= {{3{q_data.pre[31]}}, q_data.pre};
        zi    <= {{3{q_data.pim[31]}}, q_data.pim};
        cr    <= cfg.julia_mode ? cfg.julia_c_re : q_data.pre;
        ci    <= cfg.julia_mode ? cfg.julia_c_im : q_data.pim;
        first <= cfg.julia_mode;
        count <= '0;
      end
      S_WAIT: begin
        if (mul_done) begin
          in_set <= (count >= cfg.iteration_limit);
          if (run) begin
            zr    <= sat_z(t_r);
            zi    <= sat_z(t_i);
            count <= count + 16'd1;
            first <= 1'b0;
          end else begin
            rem   <= num[25:10];
            numlo <= num[9:0];
            dcnt  <= '0;
          end
        end
      end
      S_DIV: begin
        rem   <= ge ? 16'(remsh - {1'b0, cfg.iteration_limit}) : remsh[15:0];
        q     <= {q[8:0], ge};
        numlo <= {numlo[8:0], 1'b0};
        dcnt  <= dcnt + 4'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= {4'd0, rgb.blue, rgb.green, rgb.red, idx, count, py, px};
      m_tuser <= in_set;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/escape_time_fractal_pixel.sv
// Escape-time fractal pixel engine (Mandelbrot or Julia).
// Input stream: one transfer per pixel, s_tdata holds the column and row.
// The front end maps the pixel to a complex point and places it in a
// two-entry queue; the back end iterates z <- z^2 + c with three sequential
// multipliers that build each product from partial products in turn.
// Each pixel runs the multiplier loop once per iteration and once more for
// the final escape test, and an escaped point then runs a palette division.
// The multiplier loop sets the throughput: pixels are processed one at a time
// in the back end while the front end accepts the next ones into the queue.
// Output stream: one transfer per pixel with the echoed coordinate, count,
// palette index and colour; m_tuser flags a point inside the set.
// A stalled receiver holds the result in the output register; the back end
// then waits, the queue fills and s_tready drops.
// Reset (rst, synchronous) empties the pipeline and loads the default view.
// Registers are written over the APB port at byte address 4*index; write
// them only while no pixel is in flight.
`default_nettype none
module escape_time_fractal_pixel (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [etfp_pkg::INW-1:0]      s_tdata,   // pixel_x, pixel_y
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // out_x, out_y, iteration_count, palette_index, red, green, blue
  output logic [etfp_pkg::OUTW-1:0]    m_tdata,
  output logic                         m_tuser,   // inside_set
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [etfp_pkg::AW-1:0]       paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  etfp_pkg::cfg_t   cfg;
  logic             push, q_ready, q_valid, q_pop;
  etfp_pkg::point_t push_data, q_data;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_min           <= -32'sd335544320;
      cfg.y_max           <= 32'sd335544320;
      cfg.re_step         <= 32'sd1313285;
      cfg.im_step         <= 32'sd1313285;
      cfg.julia_c_re      <= -32'sd201326592;
      cfg.julia_c_im      <= 32'sd0;
      cfg.iteration_limit <= 16'd80;
      cfg.julia_mode      <= 1'b1;
    end else if (wr) begin
      case (paddr[4:2])
        etfp_pkg::REG_X_MIN:      cfg.x_min           <= pwdata;
        etfp_pkg::REG_Y_MAX:      cfg.y_max           <= pwdata;
        etfp_pkg::REG_RE_STEP:    cfg.re_step         <= pwdata;
        etfp_pkg::REG_IM_STEP:    cfg.im_step         <= pwdata;
        etfp_pkg::REG_JULIA_C_RE: cfg.julia_c_re      <= pwdata;
        etfp_pkg::REG_JULIA_C_IM: cfg.julia_c_im      <= pwdata;
        etfp_pkg::REG_ITER_LIMIT: cfg.iteration_limit <= pwdata[15:0];
        etfp_pkg::REG_JULIA_MODE: cfg.julia_mode      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      etfp_pkg::REG_X_MIN:      prdata = cfg.x_min;
      etfp_pkg::REG_Y_MAX:      prdata = cfg.y_max;
      etfp_pkg::REG_RE_STEP:    prdata = cfg.re_step;
      etfp_pkg::REG_IM_STEP:    prdata = cfg.im_step;
      etfp_pkg::REG_JULIA_C_RE: prdata = cfg.julia_c_re;
      etfp_pkg::REG_JULIA_C_IM: prdata = cfg.julia_c_im;
      etfp_pkg::REG_ITER_LIMIT: prdata = {16'd0, cfg.iteration_limit};
      etfp_pkg::REG_JULIA_MODE: prdata = {31'd0, cfg.julia_mode};
      default:                  prdata = '0;
    endcase
  end

  etfp_front u_front (
    .clk, .rst, .cfg, .s_tvalid, .s_tready, .s_tdata,
    .push, .push_data, .q_ready
  );

  etfp_queue u_queue (
    .clk, .rst, .push, .push_data, .ready(q_ready),
    .pop(q_pop), .valid(q_valid), .data(q_data)
  );

  etfp_back u_back (
    .clk, .rst, .cfg, .q_valid, .q_data, .q_pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

endmodule
`default_nettype wire

>>> hw/rtl/etfp_checker.sv
`default_nettype none
module etfp_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [71:0] m_tdata,
  input wire        m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[67:34] == 34'd0)
    else $error("point in set not black");

  a_escaped_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[43:34] != 10'd0 && m_tdata[43:34] != 10'd1)
    else $error("escaped point with palette index below two");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind escape_time_fractal_pixel etfp_checker u_etfp_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

>>> tb/sv/escape_time_fractal_pixel_test.sv
`default_nettype none
module escape_time_fractal_pixel_test;
  import etfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000000;
  localparam int HOLD_CYCLES    = 4000;

  typedef struct {
    logic [XW-1:0]   x;
    logic [XW-1:0]   y;
    logic [LIMW-1:0] count;
    logic            in_set;
    logic [IDXW-1:0] index;
    logic [CHW-1:0]  red;
    logic [CHW-1:0]  green;
    logic [CHW-1:0]  blue;
  } pixel_result_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [INW-1:0]    s_tdata;   // pixel_x, pixel_y
  logic              m_tvalid;
  logic              m_tready;
  // out_x, out_y, iteration_count, palette_index, red, green, blue
  logic [OUTW-1:0]   m_tdata;
  logic              m_tuser;   // inside_set
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AW-1:0]     paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // local copy of the view registers
  cfg_t view;

  pixel_result_t pending_pixels[$];
  int  mismatches;
  int  burst_left;
  bit  hold_request;
  int  hold_left;
  int  ready_mode;
  int  ready_phase;
  int  idle_cycles;

  escape_time_fractal_pixel u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Q.28 product, magnitude floored then signed
  function automatic longint q28_mul(input longint a, input longint b);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = ua * ub;
    p   = p >> FRACW;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic pixel_result_t iterate_pixel(input logic [XW-1:0] px,
                                                  input logic [XW-1:0] py);
    pixel_result_t res;
    longint zmax;
    longint esc;
    longint pre, pim, cr, ci, zr, zi, sr, si, zi_next;
    int unsigned count;
    int unsigned limit;
    int unsigned lvl;
    int unsigned idx;
    logic [CHW-1:0] i;
    zmax  = (longint'(1) << 34) - 1;
    esc   = longint'(400) << FRACW;
    limit = view.iteration_limit;
    pre = clamp(longint'(view.x_min) + longint'(px) * longint'(view.re_step),
                -(longint'(1) << 31), (longint'(1) << 31) - 1);
    pim = clamp(longint'(view.y_max) - longint'(py) * longint'(view.im_step),
                -(longint'(1) << 31), (longint'(1) << 31) - 1);
    if (view.julia_mode) begin
      cr = view.julia_c_re;
      ci = view.julia_c_im;
    end else begin
      cr = pre;
      ci = pim;
    end
    zr = pre;
    zi = pim;
    sr = q28_mul(zr, zr);
    si = q28_mul(zi, zi);
    count = 0;
    // Julia always takes one step before the escape test
    while ((view.julia_mode && count == 0) || (sr + si <= esc && count < limit)) begin
      zi_next = clamp(q28_mul(zr, zi) * 2 + ci, -zmax, zmax);
      zr = clamp(sr - si + cr, -zmax, zmax);
      zi = zi_next;
      sr = q28_mul(zr, zr);
      si = q28_mul(zi, zi);
      count++;
    end
    res.x      = px;
    res.y      = py;
    res.count  = count[LIMW-1:0];
    res.in_set = count >= limit;
    res.index  = '0;
    res.red    = '0;
    res.green  = '0;
    res.blue   = '0;
    if (!res.in_set) begin
      lvl = (longint'(count) * 1023) / limit;
      idx = 1024 - lvl;
      if (idx > 1023) idx = 1023;
      res.index = idx[IDXW-1:0];
      i = idx[CHW-1:0];
      case (res.index[IDXW-1:CHW])
        SEG_RED_YEL: begin res.red = 8'hFF; res.green = i; res.blue = 8'h00; end
        SEG_YEL_GRN: begin res.red = 8'hFF - i; res.green = 8'hFF; res.blue = 8'h00; end
        SEG_GRN_CYN: begin res.red = 8'h00; res.green = 8'hFF; res.blue = i; end
        default:     begin res.red = 8'h00; res.green = 8'hFF - i; res.blue = 8'hFF; end
      endcase
    end
    return res;
  endfunction

  task automatic send_pixel(input logic [XW-1:0] px, input logic [XW-1:0] py);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(INW - 2*XW){1'b0}}, py, px};
    do @(posedge clk); while (!s_tready);
    pending_pixels.push_back(iterate_pixel(px, py));
    burst_left--;
  endtask

  // wait for the block to drain before touching a register
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (index)
      REG_X_MIN:      view.x_min = value;
      REG_Y_MAX:      view.y_max = value;
      REG_RE_STEP:    view.re_step = value;
      REG_IM_STEP:    view.im_step = value;
      REG_JULIA_C_RE: view.julia_c_re = value;
      REG_JULIA_C_IM: view.julia_c_im = value;
      REG_ITER_LIMIT: view.iteration_limit = value[LIMW-1:0];
      default:        view.julia_mode = value[0];
    endcase
  endtask

  task automatic set_view(input int xm, input int ym, input int rs, input int is);
    wait_drained();
    write_reg(REG_X_MIN, xm);
    write_reg(REG_Y_MAX, ym);
    write_reg(REG_RE_STEP, rs);
    write_reg(REG_IM_STEP, is);
  endtask

  task automatic test_default_view();
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd0, 9'd511);
    send_pixel(9'd511, 9'd0);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'h155, 9'h0AA);
  endtask

  task automatic test_mandelbrot();
    wait_drained();
    write_reg(REG_JULIA_MODE, 32'd0);
    write_reg(REG_JULIA_C_RE, 32'h7FFF_FFFF);
    write_reg(REG_JULIA_C_IM, 32'h8000_0000);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd100, 9'd300);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd400, 9'd255);
    wait_drained();
    write_reg(REG_ITER_LIMIT, 32'd1);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd0, 9'd0);
  endtask

  task automatic test_limit_extremes();
    wait_drained();
    write_reg(REG_ITER_LIMIT, 32'd0);
    send_pixel(9'd256, 9'd256);
    wait_drained();
    write_reg(REG_JULIA_MODE, 32'd1);
    send_pixel(9'd256, 9'd256);
    // far view: points saturate and escape at once, so the top limit is cheap
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    write_reg(REG_ITER_LIMIT, 32'hFFFF);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd0, 9'd0);
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_pixel(9'd511, 9'd511);
    wait_drained();
    write_reg(REG_JULIA_MODE, 32'd0);
    send_pixel(9'd1, 9'd1);
  endtask

  task automatic random_config();
    int xm, ym;
    bit noise;
    noise = $urandom_range(0, 7) == 0;
    wait_drained();
    if (noise) begin
      write_reg(REG_X_MIN, $urandom);
      write_reg(REG_Y_MAX, $urandom);
      write_reg(REG_RE_STEP, $urandom);
      write_reg(REG_IM_STEP, $urandom);
      write_reg(REG_JULIA_C_RE, $urandom);
      write_reg(REG_JULIA_C_IM, $urandom);
      write_reg(REG_ITER_LIMIT, $urandom_range(0, 3) == 0 ? 32'hFFFF : $urandom_range(0, 120));
    end else begin
      xm = $urandom_range(0, 3 << 28) - (5 << 27);
      ym = $urandom_range(0, 5 << 27) - (1 << 27);
      write_reg(REG_X_MIN, xm);
      write_reg(REG_Y_MAX, ym);
      write_reg(REG_RE_STEP, $urandom_range(1 << 14, 3 << 20));
      write_reg(REG_IM_STEP, $urandom_range(1 << 14, 3 << 20));
      write_reg(REG_JULIA_C_RE, $urandom_range(0, 1 << 29) - (1 << 28));
      write_reg(REG_JULIA_C_IM, $urandom_range(0, 1 << 29) - (1 << 28));
      write_reg(REG_ITER_LIMIT, $urandom_range(1, 100));
    end
    write_reg(REG_JULIA_MODE, $urandom_range(0, 1));
  endtask

  task automatic test_random(input int phases, input int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      random_config();
      for (int n = 0; n < per_phase; n++) begin
        if (ph == 1 && n == 5) hold_request = 1'b1;
        // pause the sender until every result is back
        if (ph == 2 && n == per_phase / 2) begin
          s_tvalid <= 1'b0;
          burst_left = 0;
          while (pending_pixels.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        send_pixel($urandom_range(0, 511), $urandom_range(0, 511));
      end
    end
  endtask

  initial begin
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    burst_left   = 0;
    hold_request = 1'b0;
    view = '{x_min: -335544320, y_max: 335544320, re_step: 1313285, im_step: 1313285,
             julia_c_re: -201326592, julia_c_im: 0, iteration_limit: 80, julia_mode: 1'b1};
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_view();
    test_mandelbrot();
    test_limit_extremes();
    test_random(8, 80);
    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: stall pattern, long hold-off on request, and checking
  always @(posedge clk) begin
    pixel_result_t exp_px;
    if (rst) begin
      hold_left   <= 0;
      ready_mode  <= 0;
      ready_phase <= 0;
      m_tready    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("result with nothing expected: %h", m_tdata);
          mismatches++;
        end else begin
          exp_px = pending_pixels.pop_front();
          if (m_tdata[8:0] !== exp_px.x) begin
            $error("out_x expected %0d got %0d", exp_px.x, m_tdata[8:0]); mismatches++;
          end
          if (m_tdata[17:9] !== exp_px.y) begin
            $error("out_y expected %0d got %0d", exp_px.y, m_tdata[17:9]); mismatches++;
          end
          if (m_tdata[33:18] !== exp_px.count) begin
            $error("iteration_count expected %0d got %0d", exp_px.count, m_tdata[33:18]);
            mismatches++;
          end
          if (m_tuser !== exp_px.in_set) begin
            $error("inside_set expected %0d got %0d", exp_px.in_set, m_tuser); mismatches++;
          end
          if (m_tdata[43:34] !== exp_px.index) begin
            $error("palette_index expected %0d got %0d", exp_px.index, m_tdata[43:34]);
            mismatches++;
          end
          if (m_tdata[51:44] !== exp_px.red) begin
            $error("red expected %0d got %0d", exp_px.red, m_tdata[51:44]); mismatches++;
          end
          if (m_tdata[59:52] !== exp_px.green) begin
            $error("green expected %0d got %0d", exp_px.green, m_tdata[59:52]); mismatches++;
          end
          if (m_tdata[67:60] !== exp_px.blue) begin
            $error("blue expected %0d got %0d", exp_px.blue, m_tdata[67:60]); mismatches++;
          end
        end
      end
      ready_phase <= ready_phase + 1;
      if (ready_phase % 100 == 0) ready_mode <= $urandom_range(0, 2);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        case (ready_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 3) != 0;
          default: m_tready <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  // end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/etfp_pkg.sv
hw/rtl/etfp_front.sv
hw/rtl/etfp_queue.sv
hw/rtl/etfp_mul.sv
hw/rtl/etfp_back.sv
hw/rtl/escape_time_fractal_pixel.sv
hw/rtl/etfp_checker.sv
tb/sv/escape_time_fractal_pixel_test.sv
